// ===== rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// types and codes shared by the chained hash map and its users
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DUP       = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_NO_FREE   = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] data_out;
  } rsp_t;

endpackage

// ===== rtl/chained_hash_map.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map
// key to value map with separate chaining over a fixed pool of entries
// ----------------------------------------------------------------------------
// Requests enter on the in channel (in_valid_i, in_stall_o, in_i) and one
// response per request leaves on the out channel (out_valid_o, out_stall_i,
// out_o). Add stores a key and value, get returns the value, remove frees
// the entry. The bucket is the key modulo BUCKETS.
// One request is in work at a time. From acceptance a request passes through
// the bucket read, the chain walk and the action up to the edge that loads the
// response register; the walk reads the entry memory once per cycle. An add
// that takes an entry, or a remove behind the chain head, adds a write step.
// The next request is accepted in the cycle after that edge.
// When BUCKETS is not a power of two, a remainder unit first reduces the key,
// 4 key bits a cycle. A rejected add (pool exhausted) or an unused request code
// goes straight to the response.
// After reset the bucket memory is cleared, one bucket a cycle, while
// in_stall_o stays high. The entry pool needs no pass: a fill count stands in
// for the initial free list.
// The response waits in an output register while out_stall_i is high; the
// next request is accepted meanwhile and holds only at its own response.
// ----------------------------------------------------------------------------
module chained_hash_map #(
  parameter int BUCKETS = 64,
  parameter int ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  chm_pkg::req_t in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output chm_pkg::rsp_t out_o
);
  import chm_pkg::*;

  localparam int  BW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int  IDX_W     = $clog2(ENTRIES + 1);
  localparam bit  IS_POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int  MOD_DIG   = 4;
  localparam int  MOD_STEPS = KEY_W / MOD_DIG;
  localparam int  CW        = $clog2(MOD_STEPS);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_MOD    = 4'd2;
  localparam logic [3:0] ST_HREAD  = 4'd3;
  localparam logic [3:0] ST_HWAIT  = 4'd4;
  localparam logic [3:0] ST_WALK   = 4'd5;
  localparam logic [3:0] ST_ACT    = 4'd6;
  localparam logic [3:0] ST_ALLOC  = 4'd7;
  localparam logic [3:0] ST_UNLINK = 4'd8;
  localparam logic [3:0] ST_RESP   = 4'd9;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  link;
  } entry_t;

  function automatic logic is_entry(logic [IDX_W-1:0] idx);
    return idx < NIL;
  endfunction

  function automatic logic [BW-1:0] mod_digit(logic [BW-1:0] r, logic [MOD_DIG-1:0] d);
    logic [BW:0] t;
    t = {1'b0, r};
    for (int i = 0; i < MOD_DIG; i++) begin
      t = {t[BW-1:0], d[MOD_DIG-1-i]};
      if (t >= (BW+1)'(BUCKETS)) begin
        t = t - (BW+1)'(BUCKETS);
      end
    end
    return t[BW-1:0];
  endfunction

  entry_t           e_mem [ENTRIES];
  logic [IDX_W-1:0] b_mem [BUCKETS];

  logic [3:0]        state_q, state_d;
  logic [BW-1:0]     clr_q, clr_d;
  logic [IDX_W-1:0]  free_head_q, free_head_d;
  logic [IDX_W-1:0]  fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  rsp_t              out_q, out_d;
  req_t              req_q, req_d;
  logic [BW-1:0]     bucket_q, bucket_d;
  logic [KEY_W-1:0]  key_sh_q, key_sh_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  entry_t            prev_word_q, prev_word_d;
  logic              found_q, found_d;
  logic [1:0]        res_status_q, res_status_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;

  entry_t            e_rdata_q;
  logic [IDX_W-1:0]  b_rdata_q;
  logic              e_we, e_re, b_we, b_re;
  logic [AW-1:0]     e_waddr, e_raddr;
  entry_t            e_wdata;
  logic [BW-1:0]     b_waddr;
  logic [IDX_W-1:0]  b_wdata;
  logic              accept;
  logic [IDX_W-1:0]  fh_next;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // link of the entry at the free head; entries at or above the fill count were never written
  assign fh_next = (free_head_q >= fill_q) ? (free_head_q + IDX_W'(1)) : e_rdata_q.link;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    free_head_d  = free_head_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    cnt_d        = cnt_q;
    req_d        = req_q;
    bucket_d     = bucket_q;
    key_sh_d     = key_sh_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_word_d  = prev_word_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    e_we         = 1'b0;
    e_re         = 1'b0;
    e_waddr      = '0;
    e_raddr      = '0;
    e_wdata      = '0;
    b_we         = 1'b0;
    b_re         = 1'b0;
    b_waddr      = bucket_q;
    b_wdata      = NIL;

    case (state_q)
      ST_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_q;
        clr_d   = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_d        = in_i;
          res_status_d = STAT_NOT_FOUND;
          res_data_d   = '0;
          key_sh_d     = in_i.key;
          cnt_d        = '0;
          bucket_d     = IS_POW2 ? BW'(in_i.key & KEY_W'(BUCKETS - 1)) : '0;
          if (in_i.req_type != REQ_ADD && in_i.req_type != REQ_GET &&
              in_i.req_type != REQ_REMOVE) begin
            state_d = ST_RESP;
          end else if (in_i.req_type == REQ_ADD && !is_entry(free_head_q)) begin
            res_status_d = STAT_NO_FREE;
            state_d      = ST_RESP;
          end else begin
            state_d = IS_POW2 ? ST_HREAD : ST_MOD;
          end
        end
      end
      ST_MOD: begin
        bucket_d = mod_digit(bucket_q, key_sh_q[KEY_W-1 -: MOD_DIG]);
        key_sh_d = key_sh_q << MOD_DIG;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(MOD_STEPS - 1)) begin
          state_d = ST_HREAD;
        end
      end
      ST_HREAD: begin
        b_re    = 1'b1;
        state_d = ST_HWAIT;
      end
      ST_HWAIT: begin
        prev_d  = NIL;
        cur_d   = b_rdata_q;
        found_d = 1'b0;
        if (is_entry(b_rdata_q)) begin
          e_re    = 1'b1;
          e_raddr = b_rdata_q[AW-1:0];
          state_d = ST_WALK;
        end else begin
          state_d = ST_ACT;
        end
      end
      ST_WALK: begin
        if (e_rdata_q.key == req_q.key) begin
          found_d = 1'b1;
          state_d = ST_ACT;
        end else begin
          prev_d      = cur_q;
          prev_word_d = e_rdata_q;
          cur_d       = e_rdata_q.link;
          if (is_entry(e_rdata_q.link)) begin
            e_re    = 1'b1;
            e_raddr = e_rdata_q.link[AW-1:0];
          end else begin
            state_d = ST_ACT;
          end
        end
      end
      ST_ACT: begin
        state_d = ST_RESP;
        case (req_q.req_type)
          REQ_GET: begin
            if (found_q) begin
              res_status_d = STAT_OK;
              res_data_d   = e_rdata_q.value;
            end
          end
          REQ_ADD: begin
            if (found_q) begin
              res_status_d = STAT_DUP;
            end else begin
              e_re    = 1'b1;
              e_raddr = free_head_q[AW-1:0];
              if (is_entry(prev_q)) begin
                e_we         = 1'b1;
                e_waddr      = prev_q[AW-1:0];
                e_wdata      = prev_word_q;
                e_wdata.link = free_head_q;
              end else begin
                b_we    = 1'b1;
                b_wdata = free_head_q;
              end
              state_d = ST_ALLOC;
            end
          end
          REQ_REMOVE: begin
            if (found_q) begin
              e_we         = 1'b1;
              e_waddr      = cur_q[AW-1:0];
              e_wdata      = e_rdata_q;
              e_wdata.link = free_head_q;
              free_head_d  = cur_q;
              res_status_d = STAT_OK;
              if (is_entry(prev_q)) begin
                state_d = ST_UNLINK;
              end else begin
                b_we    = 1'b1;
                b_wdata = e_rdata_q.link;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_ALLOC: begin
        e_we          = 1'b1;
        e_waddr       = free_head_q[AW-1:0];
        e_wdata.key   = req_q.key;
        e_wdata.value = req_q.data_in;
        e_wdata.link  = NIL;
        free_head_d   = fh_next;
        if (free_head_q >= fill_q) begin
          fill_d = free_head_q + IDX_W'(1);
        end
        res_status_d = STAT_OK;
        state_d      = ST_RESP;
      end
      ST_UNLINK: begin
        e_we         = 1'b1;
        e_waddr      = prev_q[AW-1:0];
        e_wdata      = prev_word_q;
        e_wdata.link = e_rdata_q.link;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_d.status   = res_status_q;
          out_d.data_out = res_data_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      free_head_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q        <= out_d;
    req_q        <= req_d;
    bucket_q     <= bucket_d;
    key_sh_q     <= key_sh_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_word_q  <= prev_word_d;
    found_q      <= found_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
  end

  // entry pool memory
  always_ff @(posedge clk_i) begin
    if (e_we) begin
      e_mem[e_waddr] <= e_wdata;
    end
    if (e_re) begin
      e_rdata_q <= e_mem[e_raddr];
    end
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= b_wdata;
    end
    if (b_re) begin
      b_rdata_q <= b_mem[bucket_q];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NIL)
    else $error("fill count beyond pool size");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("item accepted while previous item in work");

  a_alloc_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC) |-> is_entry(free_head_q))
    else $error("allocation from an empty pool");

endmodule

// ===== dv/chained_hash_map_mirror.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_mirror
// keeps its own copy of the map, predicts each response and checks it
// ----------------------------------------------------------------------------
// Watches both channels of the chained hash map. Every accepted request is
// applied to a private model of the bucket chains and the free list. The
// model's answer is queued, and each accepted response is compared field by
// field with the oldest queued answer. The error count and the number of
// answers still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module chained_hash_map_mirror #(
  parameter int BUCKETS = 64,
  parameter int ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_stall_i,
  input  chm_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_stall_i,
  input  chm_pkg::rsp_t rsp_i,
  output int unsigned   errors_o,
  output int unsigned   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import chm_pkg::*;

  localparam int unsigned NIL = ENTRIES;

  int unsigned       chain_head [BUCKETS];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [DATA_W-1:0] slot_val   [ENTRIES];
  int unsigned       slot_next  [ENTRIES];
  int unsigned       free_slot;
  rsp_t              pending_rsp [$];

  function automatic void clear_map();
    for (int b = 0; b < BUCKETS; b++) chain_head[b] = NIL;
    for (int e = 0; e < ENTRIES; e++) begin
      slot_key[e]  = '0;
      slot_val[e]  = '0;
      slot_next[e] = e + 1;
    end
    free_slot = 0;
  endfunction

  function automatic int unsigned find_slot(input int unsigned bkt,
                                            input logic [KEY_W-1:0] key,
                                            output int unsigned prev_slot,
                                            output int unsigned tail_slot);
    int unsigned cur;
    int unsigned prior;
    int unsigned steps;
    cur   = chain_head[bkt];
    prior = NIL;
    steps = 0;
    while (cur < ENTRIES && steps < ENTRIES) begin
      if (slot_key[cur] == key) begin
        prev_slot = prior;
        tail_slot = cur;
        return cur;
      end
      prior = cur;
      cur   = slot_next[cur];
      steps++;
    end
    prev_slot = prior;
    tail_slot = prior;
    return NIL;
  endfunction

  function automatic rsp_t map_apply(input req_t r);
    int unsigned bkt;
    int unsigned prev_slot;
    int unsigned tail_slot;
    int unsigned hit;
    int unsigned slot;
    rsp_t        rsp;
    bkt          = r.key % KEY_W'(BUCKETS);
    rsp.status   = STAT_NOT_FOUND;
    rsp.data_out = '0;
    case (r.req_type)
      REQ_ADD: begin
        // pool check comes before the duplicate search
        if (free_slot >= ENTRIES) begin
          rsp.status = STAT_NO_FREE;
        end else begin
          hit = find_slot(bkt, r.key, prev_slot, tail_slot);
          if (hit < ENTRIES) begin
            rsp.status = STAT_DUP;
          end else begin
            slot            = free_slot;
            free_slot       = slot_next[slot];
            slot_key[slot]  = r.key;
            slot_val[slot]  = r.data_in;
            slot_next[slot] = NIL;
            if (tail_slot < ENTRIES) slot_next[tail_slot] = slot;
            else chain_head[bkt] = slot;
            rsp.status = STAT_OK;
          end
        end
      end
      REQ_GET: begin
        hit = find_slot(bkt, r.key, prev_slot, tail_slot);
        if (hit < ENTRIES) begin
          rsp.status   = STAT_OK;
          rsp.data_out = slot_val[hit];
        end
      end
      REQ_REMOVE: begin
        hit = find_slot(bkt, r.key, prev_slot, tail_slot);
        if (hit < ENTRIES) begin
          if (prev_slot < ENTRIES) slot_next[prev_slot] = slot_next[hit];
          else chain_head[bkt] = slot_next[hit];
          slot_next[hit] = free_slot;
          free_slot      = hit;
          rsp.status     = STAT_OK;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_t want;
    if (!rst_ni) begin
      clear_map();
      pending_rsp.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected response: status %0d data %h",
                   $time, rsp_i.status, rsp_i.data_out);
          errors_o++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_i.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d got %0d",
                     $time, want.status, rsp_i.status);
            errors_o++;
          end
          if (rsp_i.data_out !== want.data_out) begin
            $display("%0t: data_out mismatch: expected %h got %h",
                     $time, want.data_out, rsp_i.data_out);
            errors_o++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) pending_rsp.push_back(map_apply(req_i));
      pending_o <= pending_rsp.size();
    end
  end

endmodule

// ===== dv/chained_hash_map_tb.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_tb
// request stimulus, handshake pacing and verdict for the chained hash map
// ----------------------------------------------------------------------------
// A short directed run covers empty lookups, chain head, middle and tail,
// duplicate keys, key and data extremes, freed entry reuse and the unused
// request code. Random phases follow with add heavy, remove heavy and mixed
// traffic over a key pool that crowds part of the keys into four buckets,
// so chains grow long and the entry pool runs dry. The phases vary the pacing of
// both channels; one phase holds the response side off for a long
// stretch so the block backs up. The mirror module checks all responses.
// ----------------------------------------------------------------------------
module chained_hash_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chm_pkg::*;

  localparam int BUCKETS       = 64;
  localparam int ENTRIES       = 256;
  localparam int POOL_N        = 320;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 300;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned MIX_ADD [PHASES] = '{40, 88, 88, 15, 40, 88, 15, 40};
  localparam int unsigned MIX_GET [PHASES] = '{35,  8,  8, 25, 35,  8, 25, 35};
  localparam int unsigned IDLE_TX [PHASES] = '{ 0, 77,  0, 17,  0, 77,  0, 17};
  localparam int unsigned IDLE_RX [PHASES] = '{ 0,  0, 77, 17,  0,  0, 77, 17};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  req_t        in_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_ticket  = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned add_cursor   = 0;

  logic [KEY_W-1:0] key_pool [POOL_N];

  chained_hash_map #(
    .BUCKETS(BUCKETS),
    .ENTRIES(ENTRIES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  chained_hash_map_mirror #(
    .BUCKETS(BUCKETS),
    .ENTRIES(ENTRIES)
  ) u_mirror (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_stall_i(in_stall_o),
    .req_i      (in_i),
    .rsp_valid_i(out_valid_o),
    .rsp_stall_i(out_stall_i),
    .rsp_i      (out_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // response side: random stalls, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_ticket != hold_served) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_ticket;
    end else begin
      out_stall_i <= rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic req_t req_of(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                  input logic [DATA_W-1:0] data);
    req_t r;
    r.req_type = op;
    r.key      = key;
    r.data_in  = data;
    return r;
  endfunction

  function automatic req_t next_req(input int unsigned add_pct, input int unsigned get_pct);
    req_t        r;
    int unsigned roll;
    int unsigned noise;
    roll      = $urandom_range(99);
    noise     = $urandom_range(99);
    r.data_in = $urandom();
    r.key     = key_pool[$urandom_range(POOL_N - 1)];
    if (roll < add_pct) begin
      r.req_type = REQ_ADD;
      // fill traffic walks the pool in order so the entries run out
      if (add_pct >= 80) begin
        r.key      = key_pool[add_cursor];
        add_cursor = (add_cursor + 1) % POOL_N;
      end
    end else if (roll < add_pct + get_pct) begin
      r.req_type = REQ_GET;
    end else begin
      r.req_type = REQ_REMOVE;
    end
    if (noise < 4) r.key = $urandom();
    else if (noise == 99) r.req_type = REQ_UNUSED;
    return r;
  endfunction

  task automatic offer_req(input req_t r);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    // half the pool crowds into four buckets for long chains
    for (int i = 0; i < POOL_N; i++) begin
      key_pool[i] = $urandom() / BUCKETS * BUCKETS
                  + (i < POOL_N / 2 ? $urandom_range(3) : $urandom_range(BUCKETS - 1));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer_req(req_of(REQ_GET,    32'h0000_0000, 32'h0000_0000));
    offer_req(req_of(REQ_REMOVE, 32'h0000_0000, 32'hffff_ffff));
    offer_req(req_of(REQ_ADD,    32'h0000_0000, 32'hffff_ffff));
    offer_req(req_of(REQ_ADD,    32'hffff_ffff, 32'h0000_0000));
    offer_req(req_of(REQ_ADD,    32'h0000_0040, 32'h5555_5555));
    offer_req(req_of(REQ_ADD,    32'h0000_0080, 32'haaaa_aaaa));
    offer_req(req_of(REQ_ADD,    32'h0000_0000, 32'h0000_0001));
    offer_req(req_of(REQ_GET,    32'h0000_0000, 32'h0000_0000));
    offer_req(req_of(REQ_GET,    32'h0000_0080, 32'h0000_0000));
    offer_req(req_of(REQ_GET,    32'hffff_ffff, 32'hffff_ffff));
    offer_req(req_of(REQ_GET,    32'h0000_00c0, 32'h0000_0000));
    offer_req(req_of(REQ_REMOVE, 32'h0000_0040, 32'h0000_0000));
    offer_req(req_of(REQ_GET,    32'h0000_0080, 32'h0000_0000));
    offer_req(req_of(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000));
    offer_req(req_of(REQ_GET,    32'h0000_0080, 32'h0000_0000));
    offer_req(req_of(REQ_ADD,    32'h0000_0040, 32'h1234_5678));
    offer_req(req_of(REQ_UNUSED, 32'h0000_0080, 32'h0000_0000));
    offer_req(req_of(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff));
    offer_req(req_of(REQ_GET,    32'h0000_0040, 32'hffff_ffff));
    offer_req(req_of(REQ_REMOVE, 32'h0000_0080, 32'h0000_0000));
    offer_req(req_of(REQ_REMOVE, 32'hffff_ffff, 32'h0000_0000));
    offer_req(req_of(REQ_REMOVE, 32'hffff_ffff, 32'h0000_0000));
    offer_req(req_of(REQ_GET,    32'h0000_0040, 32'h0000_0000));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      tx_idle_pct  = IDLE_TX[p];
      rx_stall_pct = IDLE_RX[p];
      if (p == 4) hold_ticket <= hold_ticket + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) offer_req(next_req(MIX_ADD[p], MIX_GET[p]));
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
